// ===== hdl/jet_energy_resolution_macros.svh =====
// ----------------------------------------------------------------------------
// Jet energy resolution assertion macros
// Shared property templates for the checks inside the RTL modules.
// ----------------------------------------------------------------------------
`ifndef JET_ENERGY_RESOLUTION_MACROS_SVH
`define JET_ENERGY_RESOLUTION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JER_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define JER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/jer_pkg.sv =====
// ----------------------------------------------------------------------------
// Jet energy resolution package
// Word types, status codes, coefficient tables and elaboration-time helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package jer_pkg;

  localparam int ET_W       = 24;
  localparam int RES_W      = 20;
  localparam int BIN_W      = 3;
  localparam int NBINS      = 6;
  localparam int DEC_SCALE  = 100000;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PW       = 2;
  localparam int LOG_STEPS  = 32;
  localparam int DIV_STEPS  = 28;
  localparam int POW_LAT    = 34;
  localparam int SQRT_STEPS = 22;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ETA_OUT = 2'd1;
  localparam logic [1:0] ST_ZERO_ET = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  localparam logic [RES_W-1:0] RES_MAX = 20'hFFFFF;

  typedef struct packed {
    logic [23:0]        et;
    logic signed [15:0] eta;
  } jer_in_t;

  typedef struct packed {
    logic [19:0] rel_resolution;
    logic [1:0]  status;
  } jer_out_t;

  typedef struct packed {
    logic [23:0]      et;
    logic [BIN_W-1:0] bin;
    logic [1:0]       cls;
  } jer_job_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic [1:0]       cls;
  } jer_side_t;

  function automatic logic [19:0] coef_n(input logic [BIN_W-1:0] b);
    case (b)
      3'd0: return 20'd396859;
      3'd1: return 20'd355226;
      3'd2: return 20'd454826;
      3'd3: return 20'd462622;
      3'd4: return 20'd253324;
      default: return 20'd295397;
    endcase
  endfunction

  function automatic logic [19:0] coef_s(input logic [BIN_W-1:0] b);
    case (b)
      3'd0: return 20'd18348;
      3'd1: return 20'd24026;
      3'd2: return 20'd22652;
      3'd3: return 20'd23664;
      3'd4: return 20'd34306;
      default: return 20'd11619;
    endcase
  endfunction

  function automatic logic [19:0] coef_m(input logic [BIN_W-1:0] b);
    case (b)
      3'd0: return 20'd62627;
      3'd1: return 20'd52571;
      3'd2: return 20'd58963;
      3'd3: return 20'd48738;
      3'd4: return 20'd28662;
      default: return 20'd96086;
    endcase
  endfunction

  // Exclusive upper edges of the |eta| bins, 12 fraction bits.
  function automatic logic [16:0] eta_edge(input logic [BIN_W-1:0] b);
    case (b)
      3'd0: return 17'd2048;
      3'd1: return 17'd4096;
      3'd2: return 17'd6144;
      3'd3: return 17'd8192;
      3'd4: return 17'd12288;
      default: return 17'd20480;
    endcase
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] w;
    r = '0;
    b = 64'h1 << 62;
    w = v;
    for (int i = 0; i < 32; i++) begin
      if (w >= r + b) begin
        w = w - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Base-two logarithm with 32 fraction bits; only evaluated on constants.
  function automatic logic signed [63:0] log2_q32(input logic [63:0] v);
    logic [63:0] x;
    logic [31:0] fr;
    int          k;
    k  = 0;
    fr = '0;
    for (int i = 1; i < 64; i++) begin
      if ((v >> i) != 64'd0) k = i;
    end
    x = (k >= 31) ? (v >> (k - 31)) : (v << (31 - k));
    for (int i = 1; i <= 32; i++) begin
      x = (x * x) >> 31;
      if (x >= 64'h1_0000_0000) begin
        x = x >> 1;
        fr[32-i] = 1'b1;
      end
    end
    return $signed({k[31:0], fr});
  endfunction

  function automatic logic signed [47:0] log_coef(input logic [19:0] v);
    return 48'(log2_q32(64'(v)) - log2_q32(64'(DEC_SCALE)));
  endfunction

  // Constant factor 2^(2^-k) with 31 fraction bits for the exponent chain.
  function automatic logic [31:0] pow2_c(input int k);
    logic [63:0] c;
    c = 64'h1_0000_0000;
    for (int i = 1; i <= k; i++) begin
      c = isqrt64(c << 31);
    end
    return c[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/jer_front.sv =====
// ----------------------------------------------------------------------------
// Jet energy resolution front end
// Finds the |eta| bin and the special case of each incoming word.
// ----------------------------------------------------------------------------
`default_nettype none

module jer_front
  import jer_pkg::*;
(
  input  wire logic     push,
  input  wire logic     q_full,
  input  wire jer_in_t  in_word,
  output logic          q_push,
  output jer_job_t      job
);

  logic [16:0]      mag;
  logic [NBINS-1:0] hit;
  logic [BIN_W-1:0] bin;

  always_comb begin
    mag = in_word.eta[15] ? (17'h10000 - {1'b0, in_word.eta}) : {1'b0, in_word.eta};
    bin = '0;
    for (int i = 0; i < NBINS; i++) begin
      hit[i] = mag < eta_edge(BIN_W'(i));
    end
    for (int i = NBINS - 1; i >= 0; i--) begin
      if (hit[i]) bin = BIN_W'(i);
    end
  end

  always_comb begin
    job.et  = in_word.et;
    job.bin = bin;
    if (hit == '0) begin
      job.cls = ST_ETA_OUT;
    end else if (in_word.et == '0) begin
      job.cls = ST_ZERO_ET;
    end else begin
      job.cls = ST_OK;
    end
  end

  assign q_push = push && !q_full;

endmodule

`default_nettype wire

// ===== hdl/jer_queue.sv =====
// ----------------------------------------------------------------------------
// Jet energy resolution job queue
// Short register queue that decouples the front end from the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
`include "jet_energy_resolution_macros.svh"

module jer_queue
  import jer_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr,
  input  wire jer_job_t din,
  output logic          q_full,
  input  wire logic     rd_req,
  output logic          q_empty,
  output jer_job_t      dout
);

  jer_job_t        slot_r [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr_r;
  logic [Q_PW-1:0] rd_ptr_r;
  logic [Q_PW:0]   count_r;
  logic [Q_PW:0]   count_nxt;
  logic            rd;

  assign q_full  = count_r == (Q_PW+1)'(Q_DEPTH);
  assign q_empty = count_r == '0;
  assign rd      = rd_req && !q_empty;
  assign dout    = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr && !rd) count_nxt = count_r + 1'b1;
    if (!wr && rd) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slot_r[wr_ptr_r] <= din;
  end

  `JER_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= (Q_PW+1)'(Q_DEPTH), "queue count over depth")
  `JER_ASSERT_IMPL(a_ptr_empty, clk, rst_n, count_r == '0, wr_ptr_r == rd_ptr_r, "pointers differ when empty")

endmodule

`default_nettype wire

// ===== hdl/jer_pow2.sv =====
// ----------------------------------------------------------------------------
// Jet energy resolution exponent unit
// Pipelined 2^y with 32 fraction bits in y, truncated to an integer.
// ----------------------------------------------------------------------------
`default_nettype none

module jer_pow2
  import jer_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               adv,
  input  wire logic signed [47:0] y,
  output logic [42:0]             t
);

  localparam logic signed [47:0] Y_HI   = 48'sd41 <<< 32;
  localparam logic signed [47:0] Y_LO   = -(48'sd64 <<< 32);
  localparam logic signed [47:0] Y_BIAS = 48'sd128 <<< 32;

  logic [31:0]       pf_r   [LOG_STEPS+1];
  logic [31:0]       pp_r   [LOG_STEPS+1];
  logic signed [8:0] pn_r   [LOG_STEPS+1];
  logic              psat_r [LOG_STEPS+1];
  logic              pzer_r [LOG_STEPS+1];
  logic [47:0]       u;
  logic [42:0]       t_nxt;
  logic [42:0]       t_r;
  logic [6:0]        shr;
  logic [3:0]        shl;

  assign u = 48'(y + Y_BIAS);

  always_ff @(posedge clk) begin
    if (adv) begin
      pf_r[0]   <= u[31:0];
      pp_r[0]   <= 32'h8000_0000;
      pn_r[0]   <= $signed({1'b0, u[39:32]}) - 9'sd128;
      psat_r[0] <= y >= Y_HI;
      pzer_r[0] <= y < Y_LO;
    end
  end

  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_step
    localparam logic [31:0] C = pow2_c(g + 1);
    logic [63:0] prod;
    assign prod = pp_r[g] * C;
    always_ff @(posedge clk) begin
      if (adv) begin
        pf_r[g+1]   <= pf_r[g];
        pp_r[g+1]   <= pf_r[g][31-g] ? prod[62:31] : pp_r[g];
        pn_r[g+1]   <= pn_r[g];
        psat_r[g+1] <= psat_r[g];
        pzer_r[g+1] <= pzer_r[g];
      end
    end
  end

  always_comb begin
    shl = 4'(pn_r[LOG_STEPS] - 9'sd31);
    shr = 7'(9'sd31 - pn_r[LOG_STEPS]);
    if (psat_r[LOG_STEPS]) begin
      t_nxt = 43'h1 << 42;
    end else if (pzer_r[LOG_STEPS]) begin
      t_nxt = '0;
    end else if (pn_r[LOG_STEPS] >= 9'sd31) begin
      t_nxt = 43'(pp_r[LOG_STEPS]) << shl;
    end else begin
      t_nxt = 43'(pp_r[LOG_STEPS] >> shr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) t_r <= t_nxt;
  end

  assign t = t_r;

endmodule

`default_nettype wire

// ===== hdl/jer_back.sv =====
// ----------------------------------------------------------------------------
// Jet energy resolution datapath
// Log, power, exponent and root pipeline with the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "jet_energy_resolution_macros.svh"

module jer_back
  import jer_pkg::*;
#(
  parameter int ET_FRAC_BITS  = 8,
  parameter int OUT_FRAC_BITS = 16
)
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_empty,
  input  wire jer_job_t q_job,
  output logic          q_pop,
  output logic          empty,
  input  wire logic     pop,
  output jer_out_t      out_word
);

  localparam int ST_M1 = LOG_STEPS + 1;
  localparam int ST_M3 = ST_M1 + 2;
  localparam int ST_Y  = ST_M3 + DIV_STEPS + 1;
  localparam int ST_Z  = ST_Y + POW_LAT + 1;
  localparam int S_TOT = ST_Z + SQRT_STEPS + 1;

  localparam logic signed [39:0] ET_OFF = $signed(40'(ET_FRAC_BITS)) <<< 32;
  localparam logic signed [47:0] Y_OFF  = $signed(48'(2 * OUT_FRAC_BITS)) <<< 32;
  localparam logic [18:0] D1 = 19'd100000;
  localparam logic [18:0] D2 = 19'd200000;
  localparam logic [18:0] D3 = 19'd300000;

  localparam logic signed [47:0] LN_TAB [8] = '{
    log_coef(coef_n(3'd0)), log_coef(coef_n(3'd1)), log_coef(coef_n(3'd2)),
    log_coef(coef_n(3'd3)), log_coef(coef_n(3'd4)), log_coef(coef_n(3'd5)),
    log_coef(coef_n(3'd6)), log_coef(coef_n(3'd7))};
  localparam logic signed [47:0] LS_TAB [8] = '{
    log_coef(coef_s(3'd0)), log_coef(coef_s(3'd1)), log_coef(coef_s(3'd2)),
    log_coef(coef_s(3'd3)), log_coef(coef_s(3'd4)), log_coef(coef_s(3'd5)),
    log_coef(coef_s(3'd6)), log_coef(coef_s(3'd7))};

  logic      adv;
  logic      vld_r  [S_TOT];
  jer_side_t side_r [S_TOT];
  logic      out_vld_r;
  jer_out_t  out_word_r;
  jer_out_t  res_nxt;

  assign adv      = !out_vld_r || pop;
  assign q_pop    = adv && !q_empty;
  assign empty    = !out_vld_r;
  assign out_word = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < S_TOT; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= !q_empty;
      for (int s = 1; s < S_TOT; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= '{bin: q_job.bin, cls: q_job.cls};
      for (int s = 1; s < S_TOT; s++) side_r[s] <= side_r[s-1];
    end
  end

  // Normalise the energy so that the leading one sits at bit 31.
  logic [4:0]  msb;
  logic [31:0] lx_r [LOG_STEPS+1];
  logic [31:0] lf_r [LOG_STEPS+1];
  logic [4:0]  lk_r [LOG_STEPS+1];

  always_comb begin
    msb = '0;
    for (int i = 1; i < ET_W; i++) begin
      if (q_job.et[i]) msb = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lx_r[0] <= {8'b0, q_job.et} << (5'd31 - msb);
      lf_r[0] <= '0;
      lk_r[0] <= msb;
    end
  end

  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
    logic [63:0] sq;
    logic [32:0] tq;
    assign sq = lx_r[g] * lx_r[g];
    assign tq = sq[63:31];
    always_ff @(posedge clk) begin
      if (adv) begin
        lx_r[g+1] <= tq[32] ? tq[32:1] : tq[31:0];
        lf_r[g+1] <= lf_r[g] | (tq[32] ? (32'h8000_0000 >> g) : 32'h0);
        lk_r[g+1] <= lk_r[g];
      end
    end
  end

  // Log of the energy, then the two exponents and the power-law product.
  logic signed [39:0] m1_lg_r;
  logic signed [47:0] m2_y1_r;
  logic               m2_neg_r;
  logic [35:0]        m2_lo_r;
  logic [35:0]        m2_hi_r;
  logic signed [20:0] mm1;
  logic [16:0]        am;
  logic [37:0]        alg;
  logic [BIN_W-1:0]   bin_m;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_lg_r <= $signed({3'b000, lk_r[LOG_STEPS], lf_r[LOG_STEPS]}) - ET_OFF;
    end
  end

  always_comb begin
    bin_m = side_r[ST_M1].bin;
    mm1   = $signed({1'b0, coef_m(bin_m)}) - 21'sd100000;
    am    = 17'(mm1[20] ? -mm1 : mm1);
    alg   = 38'(m1_lg_r[39] ? -m1_lg_r : m1_lg_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_y1_r  <= (LN_TAB[bin_m] <<< 1) - (48'(m1_lg_r) <<< 1) + Y_OFF;
      m2_neg_r <= m1_lg_r[39] ^ mm1[20];
      m2_lo_r  <= am * alg[18:0];
      m2_hi_r  <= am * alg[37:19];
    end
  end

  // Long division of the product by the decimal scale, two bits a stage.
  logic [55:0]        dn_r  [DIV_STEPS+1];
  logic [16:0]        dr_r  [DIV_STEPS+1];
  logic signed [47:0] dy_r  [DIV_STEPS+1];
  logic               dng_r [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_r[0]  <= ({20'b0, m2_hi_r} << 19) + {20'b0, m2_lo_r};
      dr_r[0]  <= '0;
      dy_r[0]  <= m2_y1_r;
      dng_r[0] <= m2_neg_r;
    end
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    logic [18:0] tr;
    logic [18:0] sub;
    logic [1:0]  qd;
    always_comb begin
      tr = {dr_r[g], dn_r[g][55:54]};
      if (tr >= D3) begin
        qd = 2'd3;
        sub = D3;
      end else if (tr >= D2) begin
        qd = 2'd2;
        sub = D2;
      end else if (tr >= D1) begin
        qd = 2'd1;
        sub = D1;
      end else begin
        qd = 2'd0;
        sub = '0;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dn_r[g+1]  <= {dn_r[g][53:0], qd};
        dr_r[g+1]  <= 17'(tr - sub);
        dy_r[g+1]  <= dy_r[g];
        dng_r[g+1] <= dng_r[g];
      end
    end
  end

  logic signed [47:0] y1_r;
  logic signed [47:0] y2_r;
  logic signed [47:0] qs;
  logic [42:0]        t1;
  logic [42:0]        t2;

  always_comb begin
    qs = dng_r[DIV_STEPS] ? -$signed(48'(dn_r[DIV_STEPS])) : $signed(48'(dn_r[DIV_STEPS]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y1_r <= dy_r[DIV_STEPS];
      y2_r <= (LS_TAB[side_r[ST_Y-1].bin] <<< 1) + qs + Y_OFF;
    end
  end

  jer_pow2 u_pow_n (.clk(clk), .adv(adv), .y(y1_r), .t(t1));
  jer_pow2 u_pow_s (.clk(clk), .adv(adv), .y(y2_r), .t(t2));

  // Square root, one result bit a stage, keeping the remainder for rounding.
  logic [43:0] sz_r    [SQRT_STEPS+1];
  logic [22:0] srem_r  [SQRT_STEPS+1];
  logic [21:0] sroot_r [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sz_r[0]    <= {1'b0, t1} + {1'b0, t2};
      srem_r[0]  <= '0;
      sroot_r[0] <= '0;
    end
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    logic [24:0] trem;
    logic [24:0] trial;
    logic        ge;
    assign trem  = {srem_r[g], sz_r[g][43:42]};
    assign trial = {1'b0, sroot_r[g], 2'b01};
    assign ge    = trem >= trial;
    always_ff @(posedge clk) begin
      if (adv) begin
        sz_r[g+1]    <= {sz_r[g][41:0], 2'b00};
        srem_r[g+1]  <= ge ? 23'(trem - trial) : 23'(trem);
        sroot_r[g+1] <= {sroot_r[g][20:0], ge};
      end
    end
  end

  logic [22:0] rnd;

  always_comb begin
    rnd = {1'b0, sroot_r[SQRT_STEPS]};
    if (srem_r[SQRT_STEPS] > rnd) rnd = rnd + 1'b1;
    case (side_r[S_TOT-1].cls)
      ST_ETA_OUT: begin
        res_nxt.rel_resolution = '0;
        res_nxt.status         = ST_ETA_OUT;
      end
      ST_ZERO_ET: begin
        res_nxt.rel_resolution = RES_MAX;
        res_nxt.status         = ST_ZERO_ET;
      end
      default: begin
        if (rnd > 23'(RES_MAX)) begin
          res_nxt.rel_resolution = RES_MAX;
          res_nxt.status         = ST_SAT;
        end else begin
          res_nxt.rel_resolution = rnd[RES_W-1:0];
          res_nxt.status         = ST_OK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_r[S_TOT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_word_r <= res_nxt;
  end

  `JER_ASSERT_NEXT(a_stall_hold, clk, rst_n, !adv, $stable(vld_r[S_TOT-1]), "pipeline moved while stalled")
  `JER_ASSERT_IMPL(a_eta_zero, clk, rst_n, out_vld_r && out_word_r.status == ST_ETA_OUT, out_word_r.rel_resolution == '0, "eta outside table with non-zero result")

endmodule

`default_nettype wire

// ===== hdl/jet_energy_resolution.sv =====
// ----------------------------------------------------------------------------
// Jet energy resolution
// Relative jet energy resolution sqrt(N^2 + S^2*Et^(m+1))/Et per jet word.
//
//   Channel  Handshake       Word
//   input    push / full     in_word  (et, eta)
//   output   empty / pop     out_word (rel_resolution, status)
//
// One word is accepted per clock cycle while full is low. The pipeline holds the
// 32-step logarithm, the 28-stage division by the decimal scale, the two 34-stage
// exponent units and the 22-stage root.
// Reset is synchronous and empties the queue and the pipeline.
// A held output stalls the whole pipeline; the four-word queue then fills and
// raises full.
// ----------------------------------------------------------------------------
`default_nettype none

module jet_energy_resolution
  import jer_pkg::*;
#(
  parameter int ET_FRAC_BITS  = 8,
  parameter int OUT_FRAC_BITS = 16
)
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  output logic         full,
  input  wire jer_in_t in_word,
  output logic         empty,
  input  wire logic    pop,
  output jer_out_t     out_word
);

  logic     q_push;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  jer_job_t job;
  jer_job_t q_job;

  assign full = q_full;

  jer_front u_front (
    .push    (push),
    .q_full  (q_full),
    .in_word (in_word),
    .q_push  (q_push),
    .job     (job)
  );

  jer_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_push),
    .din     (job),
    .q_full  (q_full),
    .rd_req  (q_pop),
    .q_empty (q_empty),
    .dout    (q_job)
  );

  jer_back #(
    .ET_FRAC_BITS  (ET_FRAC_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_job    (q_job),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

endmodule

`default_nettype wire
